[design/ber_pkg.sv]
// BER TLV parser package: item and event types, event and error codes.
// No dependencies; used by every module of the parser.
package ber_pkg;

    // Event kinds
    localparam logic [2:0] EV_HEADER  = 3'd0;
    localparam logic [2:0] EV_CONTENT = 3'd1;
    localparam logic [2:0] EV_ARC     = 3'd2;
    localparam logic [2:0] EV_LVL_END = 3'd3;
    localparam logic [2:0] EV_DONE    = 3'd4;
    localparam logic [2:0] EV_ERROR   = 3'd5;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_DEPTH    = 2'd1;
    localparam logic [1:0] ERR_LEN      = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // Universal tags
    localparam logic [27:0] TAG_INT       = 28'h02;
    localparam logic [27:0] TAG_BITSTR    = 28'h03;
    localparam logic [27:0] TAG_OCTSTR    = 28'h04;
    localparam logic [27:0] TAG_OID       = 28'h06;
    localparam logic [27:0] TAG_SEQ       = 28'h10;
    localparam logic [27:0] TAG_SET       = 28'h11;
    localparam logic [27:0] TAG_PRINTABLE = 28'h13;
    localparam logic [27:0] TAG_IA5       = 28'h16;

    localparam logic [4:0] TAG_HIGH_FORM = 5'h1f;
    localparam logic [3:0] RESULT_CAP    = 4'd10;

    // One input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_message;
    } t_item;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  code;
        logic [27:0] tag;
        logic [1:0]  cls;
        logic        cons;
        logic [31:0] len;
        logic [3:0]  lvl;
        logic [31:0] value;
        logic        last;
    } t_event;

    function automatic t_event mk_ev(input logic [2:0] kind, input logic [1:0] code,
                                     input logic elem, input logic [27:0] tag,
                                     input logic [1:0] cls, input logic cons,
                                     input logic [31:0] len, input logic [3:0] lvl,
                                     input logic [31:0] value);
        t_event e;
        e.kind  = kind;
        e.code  = code;
        e.tag   = elem ? tag : '0;
        e.cls   = elem ? cls : '0;
        e.cons  = elem ? cons : 1'b0;
        e.len   = elem ? len : '0;
        e.lvl   = lvl;
        e.value = value;
        e.last  = 1'b0;
        return e;
    endfunction

endpackage

[design/ber_front.sv]
// BER TLV parser front: two-entry queue of accepted input items.
// Depends on ber_pkg (t_item).
module ber_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ber_pkg::t_item i_item,
    output logic           o_item_valid,
    output ber_pkg::t_item o_item,
    input  logic           i_pop
);
    import ber_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_ready      = (r_cnt != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    // queue storage and pointers
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

endmodule

[design/ber_parser.sv]
// BER TLV parser back end: identifier/length decode, level stack, event output.
// Depends on ber_pkg (types, codes, mk_ev).
module ber_parser #(
    parameter int MAX_DEPTH        = 8,
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  ber_pkg::t_item  i_item,
    output logic            o_pop,
    output logic            o_ev_valid,
    output ber_pkg::t_event o_ev,
    input  logic            i_ev_ready
);
    import ber_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ID, PH_TAGHI, PH_LEN1, PH_LENN, PH_DATA, PH_OID, PH_SKIP, PH_ERR
    } t_phase;
    typedef enum logic [1:0] {SQ_FETCH, SQ_HDR, SQ_ARC2, SQ_FIN} t_seq;

    t_seq            r_seq,   n_seq;
    t_phase          r_phase, n_phase;
    logic [27:0]     r_tag,   n_tag;
    logic [1:0]      r_cls,   n_cls;
    logic            r_cons,  n_cons;
    logic [31:0]     r_len,   n_len;
    logic [2:0]      r_lbl,   n_lbl;
    logic [31:0]     r_pos,   n_pos;
    logic [31:0]     r_eend,  n_eend;
    logic [DW-1:0]   r_depth, n_depth;
    logic [31:0]     r_arc,   n_arc;
    logic            r_oidf,  n_oidf;
    logic [31:0]     r_arc2,  n_arc2;
    logic [3:0]      r_cnt,   n_cnt;
    logic [31:0]     r_stack [MAX_DEPTH];
    t_event          r_pend;
    logic            r_pv;
    logic            r_pk;
    t_event          r_out;
    logic            r_ov;

    logic            out_free, can_put, move;
    logic            put_req, put_go, item_end, stack_we;
    t_event          put_ev;
    t_phase          ph;
    logic [DW-1:0]   dep;
    logic [31:0]     pos1;
    logic [32:0]     sum;
    logic [31:0]     v_arc;
    logic [DW-1:0]   dm1;
    logic [3:0]      cnt_cur;
    logic            cons_v;
    logic [2:0]      lbl_d;
    logic [7:0]      b;

    assign out_free   = !r_ov || i_ev_ready;
    assign can_put    = !r_pv || out_free;
    assign o_ev_valid = r_ov;
    assign o_ev       = r_out;
    assign b          = i_item.data_byte;
    assign sum        = {1'b0, r_pos} + {1'b0, r_len};
    assign v_arc      = {r_arc[24:0], b[6:0]};
    assign dm1        = r_depth - DW'(1);
    assign cnt_cur    = (r_seq == SQ_FETCH) ? 4'd0 : r_cnt;
    assign cons_v     = r_cons || (r_cls == 2'd0 && (r_tag == TAG_SEQ || r_tag == TAG_SET));
    assign lbl_d      = (r_lbl != 3'd0) ? r_lbl - 3'd1 : 3'd0;
    assign put_go     = put_req && (cnt_cur < RESULT_CAP);
    assign move       = r_pv && out_free && (r_pk || put_go);

    // parse sequencer: one input byte, then follow-on steps for header/arc/unwind
    always_comb begin
        n_seq = r_seq;   n_phase = r_phase; n_tag = r_tag;   n_cls = r_cls;
        n_cons = r_cons; n_len = r_len;     n_lbl = r_lbl;   n_pos = r_pos;
        n_eend = r_eend; n_depth = r_depth; n_arc = r_arc;   n_oidf = r_oidf;
        n_arc2 = r_arc2;
        put_req = 1'b0; put_ev = '0; item_end = 1'b0; o_pop = 1'b0; stack_we = 1'b0;
        ph = r_phase; dep = r_depth; pos1 = r_pos + 32'd1;
        case (r_seq)
            SQ_FETCH: begin
                if (i_item_valid && can_put) begin
                    o_pop = 1'b1;
                    if (i_item.start_of_message) begin
                        ph = PH_ID; dep = '0; pos1 = 32'd1;
                        n_phase = PH_ID; n_depth = '0; n_pos = '0;
                    end
                    if (ph == PH_IDLE || ph == PH_ERR) begin
                        item_end = 1'b1;
                    end else begin
                        n_pos = pos1;
                        case (ph)
                            PH_ID: begin
                                n_cls = b[7:6]; n_cons = b[5]; n_len = '0; item_end = 1'b1;
                                if (b[4:0] == TAG_HIGH_FORM) begin
                                    n_tag = '0; n_phase = PH_TAGHI;
                                end else begin
                                    n_tag = {23'd0, b[4:0]}; n_phase = PH_LEN1;
                                end
                            end
                            PH_TAGHI: begin
                                item_end = 1'b1;
                                if (r_tag[27:21] != 7'd0) begin
                                    put_req = 1'b1; n_phase = PH_ERR;
                                    put_ev = mk_ev(EV_ERROR, ERR_OVERFLOW, 1'b0, r_tag, r_cls,
                                                   r_cons, r_len, 4'(dep), '0);
                                end else begin
                                    n_tag = {r_tag[20:0], b[6:0]};
                                    if (!b[7]) n_phase = PH_LEN1;
                                end
                            end
                            PH_LEN1: begin
                                n_len = '0;
                                if (b[7]) begin
                                    if (b[6:0] > 7'(MAX_LENGTH_BYTES)) begin
                                        put_req = 1'b1; n_phase = PH_ERR; item_end = 1'b1;
                                        put_ev = mk_ev(EV_ERROR, ERR_LEN, 1'b0, r_tag, r_cls,
                                                       r_cons, r_len, 4'(dep), '0);
                                    end else if (b[6:0] == 7'd0) begin
                                        n_seq = SQ_HDR;
                                    end else begin
                                        n_lbl = b[2:0]; n_phase = PH_LENN; item_end = 1'b1;
                                    end
                                end else begin
                                    n_len = {24'd0, b}; n_seq = SQ_HDR;
                                end
                            end
                            PH_LENN: begin
                                n_len = {r_len[23:0], b}; n_lbl = lbl_d;
                                if (lbl_d == 3'd0) n_seq = SQ_HDR;
                                else item_end = 1'b1;
                            end
                            PH_DATA: begin
                                put_req = 1'b1;
                                put_ev = mk_ev(EV_CONTENT, ERR_NONE, 1'b1, r_tag, r_cls, r_cons,
                                               r_len, 4'(dep), {24'd0, b});
                                if (pos1 == r_eend) n_seq = SQ_FIN;
                                else item_end = 1'b1;
                            end
                            PH_OID: begin
                                if (r_arc[31:25] != 7'd0) begin
                                    put_req = 1'b1; n_phase = PH_ERR; item_end = 1'b1;
                                    put_ev = mk_ev(EV_ERROR, ERR_OVERFLOW, 1'b0, r_tag, r_cls,
                                                   r_cons, r_len, 4'(dep), '0);
                                end else begin
                                    n_arc = v_arc;
                                    if (!b[7]) begin
                                        n_arc = '0;
                                        put_req = 1'b1;
                                        if (r_oidf) begin
                                            // first subidentifier splits into two arcs
                                            n_oidf = 1'b0; n_seq = SQ_ARC2;
                                            if (v_arc < 32'd40) begin
                                                put_ev = mk_ev(EV_ARC, ERR_NONE, 1'b1, r_tag,
                                                    r_cls, r_cons, r_len, 4'(dep), 32'd0);
                                                n_arc2 = v_arc;
                                            end else if (v_arc < 32'd80) begin
                                                put_ev = mk_ev(EV_ARC, ERR_NONE, 1'b1, r_tag,
                                                    r_cls, r_cons, r_len, 4'(dep), 32'd1);
                                                n_arc2 = v_arc - 32'd40;
                                            end else begin
                                                put_ev = mk_ev(EV_ARC, ERR_NONE, 1'b1, r_tag,
                                                    r_cls, r_cons, r_len, 4'(dep), 32'd2);
                                                n_arc2 = v_arc - 32'd80;
                                            end
                                        end else begin
                                            put_ev = mk_ev(EV_ARC, ERR_NONE, 1'b1, r_tag, r_cls,
                                                           r_cons, r_len, 4'(dep), v_arc);
                                            if (pos1 == r_eend) n_seq = SQ_FIN;
                                            else item_end = 1'b1;
                                        end
                                    end else begin
                                        if (pos1 == r_eend) n_seq = SQ_FIN;
                                        else item_end = 1'b1;
                                    end
                                end
                            end
                            PH_SKIP: begin
                                if (pos1 == r_eend) n_seq = SQ_FIN;
                                else item_end = 1'b1;
                            end
                            default: begin
                                n_phase = PH_IDLE; item_end = 1'b1;
                            end
                        endcase
                    end
                end
            end
            SQ_HDR: begin
                if (can_put) begin
                    put_req = 1'b1;
                    n_seq = SQ_FETCH;
                    if (sum[32]) begin
                        n_phase = PH_ERR; item_end = 1'b1;
                        put_ev = mk_ev(EV_ERROR, ERR_LEN, 1'b0, r_tag, r_cls, r_cons, r_len,
                                       4'(r_depth), '0);
                    end else if (cons_v && r_len != 32'd0 && r_depth >= DW'(MAX_DEPTH)) begin
                        n_cons = cons_v; n_phase = PH_ERR; item_end = 1'b1;
                        put_ev = mk_ev(EV_ERROR, ERR_DEPTH, 1'b0, r_tag, r_cls, cons_v, r_len,
                                       4'(r_depth), '0);
                    end else begin
                        n_cons = cons_v;
                        put_ev = mk_ev(EV_HEADER, ERR_NONE, 1'b1, r_tag, r_cls, cons_v, r_len,
                                       4'(r_depth), '0);
                        if (r_len == 32'd0) begin
                            n_seq = SQ_FIN;
                        end else if (cons_v) begin
                            stack_we = 1'b1; n_depth = r_depth + DW'(1);
                            n_phase = PH_ID; item_end = 1'b1;
                        end else begin
                            n_eend = sum[31:0]; item_end = 1'b1; n_phase = PH_SKIP;
                            if (r_cls == 2'd0) begin
                                if (r_tag == TAG_INT || r_tag == TAG_BITSTR ||
                                    r_tag == TAG_OCTSTR || r_tag == TAG_PRINTABLE ||
                                    r_tag == TAG_IA5) begin
                                    n_phase = PH_DATA;
                                end else if (r_tag == TAG_OID) begin
                                    n_phase = PH_OID; n_arc = '0; n_oidf = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            SQ_ARC2: begin
                if (can_put) begin
                    put_req = 1'b1;
                    put_ev = mk_ev(EV_ARC, ERR_NONE, 1'b1, r_tag, r_cls, r_cons, r_len,
                                   4'(r_depth), r_arc2);
                    if (r_pos == r_eend) begin
                        n_seq = SQ_FIN;
                    end else begin
                        n_seq = SQ_FETCH; item_end = 1'b1;
                    end
                end
            end
            SQ_FIN: begin
                // close one level per cycle while the pending stage can take an event
                if (can_put) begin
                    if (r_depth != '0 && r_stack[dm1[SW-1:0]] <= r_pos) begin
                        n_depth = dm1;
                        if (dm1 != '0 && cnt_cur < RESULT_CAP - 4'd1) begin
                            put_req = 1'b1;
                            put_ev = mk_ev(EV_LVL_END, ERR_NONE, 1'b0, r_tag, r_cls, r_cons,
                                           r_len, 4'(dm1), '0);
                        end
                    end else if (r_depth == '0) begin
                        put_req = 1'b1;
                        put_ev = mk_ev(EV_DONE, ERR_NONE, 1'b0, r_tag, r_cls, r_cons, r_len,
                                       4'd0, '0);
                        n_phase = PH_IDLE; n_seq = SQ_FETCH; item_end = 1'b1;
                    end else begin
                        n_phase = PH_ID; n_seq = SQ_FETCH; item_end = 1'b1;
                    end
                end
            end
            default: n_seq = SQ_FETCH;
        endcase
        n_cnt = cnt_cur + {3'd0, put_go};
    end

    // state, level stack, pending event and output register
    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack[r_depth[SW-1:0]] <= sum[31:0];
        end
        if (move) begin
            // last flag is the lowest bit of the event
            r_out <= {r_pend[$bits(t_event)-1:1], r_pk};
        end
        if (put_go) begin
            r_pend <= put_ev;
        end
        r_arc2 <= n_arc2;
        if (!i_rst_n) begin
            r_seq <= SQ_FETCH; r_phase <= PH_IDLE; r_tag <= '0; r_cls <= '0;
            r_cons <= 1'b0; r_len <= '0; r_lbl <= '0; r_pos <= '0; r_eend <= '0;
            r_depth <= '0; r_arc <= '0; r_oidf <= 1'b0; r_cnt <= '0;
            r_pv <= 1'b0; r_pk <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_seq <= n_seq; r_phase <= n_phase; r_tag <= n_tag; r_cls <= n_cls;
            r_cons <= n_cons; r_len <= n_len; r_lbl <= n_lbl; r_pos <= n_pos;
            r_eend <= n_eend; r_depth <= n_depth; r_arc <= n_arc; r_oidf <= n_oidf;
            r_cnt <= n_cnt;
            if (move) r_ov <= 1'b1;
            else if (i_ev_ready) r_ov <= 1'b0;
            if (put_go) begin
                r_pv <= 1'b1; r_pk <= item_end;
            end else if (move) begin
                r_pv <= 1'b0;
            end else if (item_end && r_pv) begin
                r_pk <= 1'b1;
            end
        end
    end

endmodule

[design/ber_tlv_stream_parser_core.sv]
// Top level of the streaming BER TLV parser.
// Depends on ber_pkg, ber_front (input queue) and ber_parser (decode and events).
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-----------------------------------------------
//  input   | i_valid | o_ready | i_data_byte, i_start_of_message
//  output  | o_valid | i_ready | o_event_kind .. o_item_value, o_last_of_run
//
// A byte is decoded in the SQ_FETCH step; a header adds the SQ_HDR step, a first OID
// subidentifier the SQ_ARC2 step, and an element end one SQ_FIN step per closed level
// plus one. Events leave one per cycle while i_ready is high, through a one-deep hold
// stage and an output register; the two-entry input queue keeps accepting while the back end works, until full.
// Reset is synchronous, active low, and leaves the parser idle awaiting a start.
module ber_tlv_stream_parser_core #(
    parameter int MAX_DEPTH        = 8,
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_kind,
    output logic [1:0]  o_error_code,
    output logic [27:0] o_tag_number,
    output logic [1:0]  o_tag_class,
    output logic        o_is_constructed,
    output logic [31:0] o_content_length,
    output logic [3:0]  o_nesting_level,
    output logic [31:0] o_item_value,
    output logic        o_last_of_run
);
    import ber_pkg::*;

    t_item  in_item;
    t_item  q_item;
    logic   q_valid;
    logic   q_pop;
    t_event ev;

    assign in_item.data_byte        = i_data_byte;
    assign in_item.start_of_message = i_start_of_message;

    ber_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (in_item),
        .o_item_valid (q_valid),
        .o_item       (q_item),
        .i_pop        (q_pop)
    );

    ber_parser #(
        .MAX_DEPTH        (MAX_DEPTH),
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_ev_valid   (o_valid),
        .o_ev         (ev),
        .i_ev_ready   (i_ready)
    );

    assign o_event_kind     = ev.kind;
    assign o_error_code     = ev.code;
    assign o_tag_number     = ev.tag;
    assign o_tag_class      = ev.cls;
    assign o_is_constructed = ev.cons;
    assign o_content_length = ev.len;
    assign o_nesting_level  = ev.lvl;
    assign o_item_value     = ev.value;
    assign o_last_of_run    = ev.last;

endmodule

[tb/tb_ber_tlv_stream_parser_core.sv]
`timescale 1ns / 100ps
// Testbench for ber_tlv_stream_parser_core: random and directed BER byte streams
// are checked against a behavioral decoder kept in a scoreboard class. Depends on ber_pkg.
module tb_ber_tlv_stream_parser_core;
    import ber_pkg::*;

    localparam int DEPTH_MAX = 8;
    localparam int LEN_BYTES_MAX = 4;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ID, ST_TAGHI, ST_LEN1, ST_LENN, ST_DATA, ST_OID, ST_SKIP, ST_ERR
    } t_phase;

    // Behavioral decoder plus queue of pending events
    class ber_scoreboard;
        t_phase      phase;
        logic [27:0] tag;
        logic [1:0]  cls;
        logic        cons;
        logic [31:0] len;
        logic [2:0]  len_left;
        logic [31:0] pos;
        logic [31:0] elem_end;
        logic [31:0] lvl_end [DEPTH_MAX];
        logic [3:0]  depth;
        logic [31:0] arc;
        logic        oid_first;
        t_event      pending[$];
        t_event      run[$];
        int          mismatches;

        function new();
            phase = ST_IDLE; tag = 0; cls = 0; cons = 0; len = 0; len_left = 0;
            pos = 0; elem_end = 0; depth = 0; arc = 0; oid_first = 0;
            mismatches = 0;
        endfunction

        function void emit(logic [2:0] kind, logic [1:0] code, logic [31:0] val, bit elem);
            t_event e;
            if (run.size() >= 10) return;
            e = '0;
            e.kind = kind; e.code = code; e.value = val; e.lvl = depth;
            if (elem) begin
                e.tag = tag; e.cls = cls; e.cons = cons; e.len = len;
            end
            run.push_back(e);
        endfunction

        function void raise_error(logic [1:0] code);
            emit(EV_ERROR, code, 0, 0);
            phase = ST_ERR;
        endfunction

        function void close_element();
            while (depth > 0 && lvl_end[depth-1] <= pos) begin
                depth--;
                if (depth > 0 && run.size() < 9) emit(EV_LVL_END, ERR_NONE, 0, 0);
            end
            if (depth == 0) begin
                emit(EV_DONE, ERR_NONE, 0, 0);
                phase = ST_IDLE;
            end else begin
                phase = ST_ID;
            end
        endfunction

        function void header_complete();
            logic [32:0] fin;
            bit c;
            fin = {1'b0, pos} + {1'b0, len};
            c = cons || (cls == 0 && (tag == TAG_SEQ || tag == TAG_SET));
            if (fin[32]) begin
                raise_error(ERR_LEN);
                return;
            end
            cons = c;
            if (c && len != 0 && depth >= DEPTH_MAX) begin
                raise_error(ERR_DEPTH);
                return;
            end
            emit(EV_HEADER, ERR_NONE, 0, 1);
            if (len == 0) begin
                close_element();
                return;
            end
            if (c) begin
                lvl_end[depth] = fin[31:0];
                depth++;
                phase = ST_ID;
                return;
            end
            elem_end = fin[31:0];
            phase = ST_SKIP;
            if (cls == 0) begin
                if (tag inside {TAG_INT, TAG_BITSTR, TAG_OCTSTR, TAG_PRINTABLE, TAG_IA5})
                    phase = ST_DATA;
                else if (tag == TAG_OID) begin
                    phase = ST_OID; arc = 0; oid_first = 1;
                end
            end
        endfunction

        function void arc_byte(logic [7:0] b);
            logic [31:0] v, first;
            if (arc[31:25] != 0) begin
                raise_error(ERR_OVERFLOW);
                return;
            end
            arc = {arc[24:0], b[6:0]};
            if (!b[7]) begin
                v = arc; arc = 0;
                if (oid_first) begin
                    first = (v < 80) ? v / 40 : 2;
                    emit(EV_ARC, ERR_NONE, first, 1);
                    emit(EV_ARC, ERR_NONE, v - 40 * first, 1);
                    oid_first = 0;
                end else begin
                    emit(EV_ARC, ERR_NONE, v, 1);
                end
            end
            if (pos == elem_end) close_element();
        endfunction

        // Note one accepted input item
        function void note_input(logic [7:0] b, logic som);
            int n;
            run.delete();
            if (som) begin
                depth = 0; pos = 0; phase = ST_ID;
            end
            if (phase == ST_IDLE || phase == ST_ERR) return;
            pos++;
            case (phase)
                ST_ID: begin
                    cls = b[7:6]; cons = b[5]; len = 0;
                    if (b[4:0] == TAG_HIGH_FORM) begin
                        tag = 0; phase = ST_TAGHI;
                    end else begin
                        tag = {23'd0, b[4:0]}; phase = ST_LEN1;
                    end
                end
                ST_TAGHI: begin
                    if (tag[27:21] != 0) raise_error(ERR_OVERFLOW);
                    else begin
                        tag = {tag[20:0], b[6:0]};
                        if (!b[7]) phase = ST_LEN1;
                    end
                end
                ST_LEN1: begin
                    len = 0;
                    if (b[7]) begin
                        n = b[6:0];
                        if (n > LEN_BYTES_MAX) raise_error(ERR_LEN);
                        else if (n == 0) header_complete();
                        else begin
                            len_left = 3'(n); phase = ST_LENN;
                        end
                    end else begin
                        len = {24'd0, b};
                        header_complete();
                    end
                end
                ST_LENN: begin
                    len = {len[23:0], b};
                    if (len_left > 0) len_left--;
                    if (len_left == 0) header_complete();
                end
                ST_DATA: begin
                    emit(EV_CONTENT, ERR_NONE, {24'd0, b}, 1);
                    if (pos == elem_end) close_element();
                end
                ST_OID: arc_byte(b);
                ST_SKIP: if (pos == elem_end) close_element();
                default: phase = ST_IDLE;
            endcase
            if (run.size() > 0) run[run.size()-1].last = 1'b1;
            foreach (run[i]) pending.push_back(run[i]);
        endfunction

        // Compare one accepted event with the oldest expectation
        function void check_event(t_event got);
            t_event exp_ev;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected event %p", got);
                return;
            end
            exp_ev = pending.pop_front();
            if (got !== exp_ev) begin
                mismatches++;
                if (mismatches <= 10) $display("event mismatch: exp %p got %p", exp_ev, got);
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, in_ready, out_valid, out_ready;
    logic [7:0]  data_byte;
    logic        som;
    t_event      got;

    ber_tlv_stream_parser_core u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_data_byte(data_byte), .i_start_of_message(som),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_event_kind(got.kind), .o_error_code(got.code), .o_tag_number(got.tag),
        .o_tag_class(got.cls), .o_is_constructed(got.cons),
        .o_content_length(got.len), .o_nesting_level(got.lvl),
        .o_item_value(got.value), .o_last_of_run(got.last)
    );

    ber_scoreboard sb;
    logic [7:0] msg[$];
    int idle_cycles;
    int burst_left;
    int stall_mode;

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Send one byte, bursty gaps between items; valid stays high within a burst
    task automatic send_byte(logic [7:0] b, logic s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        data_byte <= b;
        som       <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(b, s);
    endtask

    task automatic send_msg();
        foreach (msg[i]) send_byte(msg[i], i == 0);
    endtask

    // Build a random well-formed element into a byte list
    function automatic void build_elem(ref logic [7:0] o[$], input int lvl);
        logic [7:0] body[$];
        int kind, n;
        logic [7:0] id;
        kind = (lvl >= 3) ? $urandom_range(1, 5) : $urandom_range(0, 5);
        case (kind)
            0: begin
                n = $urandom_range(0, 3);
                repeat (n) build_elem(body, lvl + 1);
                id = $urandom_range(0, 1) ? 8'h30 : 8'hA1;
            end
            1, 2: begin
                id = {3'b000, 5'(TAG_INT) + 5'($urandom_range(0, 2))};
                if ($urandom_range(0, 3) == 0) id = 8'h13;
                n = $urandom_range(0, 6);
                repeat (n) body.push_back(8'($urandom));
            end
            3: begin
                id = 8'h06;
                n = $urandom_range(0, 4);
                repeat (n) begin
                    if ($urandom_range(0, 2) == 0)
                        body.push_back(8'h80 | 8'($urandom_range(1, 127)));
                    body.push_back(8'($urandom_range(0, 127)));
                end
            end
            4: begin
                id = {2'($urandom_range(0, 3)), 1'b0, 5'h1f};
                body.push_back(8'h81); body.push_back(8'($urandom_range(0, 127)));
                o.push_back(id);
                foreach (body[i]) o.push_back(body[i]);
                body.delete();
                n = $urandom_range(0, 3);
                repeat (n) body.push_back(8'($urandom));
                o.push_back(n[7:0]);
                foreach (body[i]) o.push_back(body[i]);
                return;
            end
            default: begin
                id = {2'($urandom_range(1, 3)), 1'b0, 5'($urandom_range(0, 30))};
                n = $urandom_range(0, 4);
                repeat (n) body.push_back(8'($urandom));
            end
        endcase
        o.push_back(id);
        n = body.size();
        if (n < 128 && $urandom_range(0, 3) == 0) begin
            o.push_back(8'h81); o.push_back(n[7:0]);
        end else if (n < 128) o.push_back(n[7:0]);
        else begin
            o.push_back(8'h82); o.push_back(n[15:8]); o.push_back(n[7:0]);
        end
        foreach (body[i]) o.push_back(body[i]);
    endfunction

    task automatic directed();
        // primitive INTEGER as top element, extreme bytes
        msg = '{8'h02, 8'h02, 8'h00, 8'hFF}; send_msg();
        // OID with first arc < 80 and >= 80, and multi-byte arcs
        msg = '{8'h06, 8'h05, 8'h2A, 8'h86, 8'h48, 8'hFF, 8'h7F}; send_msg();
        msg = '{8'h06, 8'h02, 8'h81, 8'h10}; send_msg();
        // zero-length OID and zero-length SEQUENCE
        msg = '{8'h06, 8'h00}; send_msg();
        msg = '{8'h30, 8'h80}; send_msg();
        // nested levels, child overrunning the parent, skipped content
        msg = '{8'h30, 8'h08, 8'h31, 8'h03, 8'h05, 8'h01, 8'h00, 8'h04, 8'h02, 8'hAA};
        send_msg();
        // BIT STRING, PrintableString, IA5 inside SEQUENCE, long length
        msg = '{8'h30, 8'h84, 8'h00, 8'h00, 8'h00, 8'h09, 8'h03, 8'h01, 8'h55,
                8'h13, 8'h01, 8'h41, 8'h16, 8'h01, 8'h7A};
        send_msg();
        // high tag form, private class, long length form
        msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h81, 8'h01, 8'h00}; send_msg();
        // tag overflow
        msg = '{8'h1F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h00}; send_msg();
        // too many length bytes, then ignored bytes until next start
        msg = '{8'h04, 8'h85, 8'h00, 8'h01}; send_msg();
        // end offset beyond 32 bits
        msg = '{8'h04, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF}; send_msg();
        // arc overflow
        msg = '{8'h06, 8'h07, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h01}; send_msg();
        // nesting too deep
        msg.delete();
        repeat (9) begin
            msg.push_back(8'h30); msg.push_back(8'h7F);
        end
        send_msg();
        // stack of eight closing at once
        msg.delete();
        for (int i = 0; i < 8; i++) begin
            msg.push_back(8'h30); msg.push_back(8'(17 - 2 * i));
        end
        msg.push_back(8'h05); msg.push_back(8'h01); msg.push_back(8'h00);
        send_msg();
        // bytes in idle without start are ignored
        send_byte(8'h30, 1'b0);
    endtask

    initial begin
        int sent;
        sb = new();
        rst_n = 0; in_valid = 0; data_byte = 0; som = 0; burst_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        sent = 0;
        while (sent < 190) begin
            msg.delete();
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 10)) msg.push_back(8'($urandom));
            end else begin
                build_elem(msg, 0);
                if ($urandom_range(0, 9) == 0) msg.delete(msg.size() - 1);
                if ($urandom_range(0, 9) == 0)
                    msg[$urandom_range(0, msg.size()-1)] = 8'($urandom);
            end
            if (msg.size() > 0) send_msg();
            sent += msg.size();
        end
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: stall pattern changes occasionally
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready   <= 1'b0;
            stall_mode  <= 0;
            idle_cycles <= 0;
        end else begin
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 1) != 0);
                default: out_ready <= ($urandom_range(0, 4) == 0);
            endcase
            if (out_valid && out_ready) sb.check_event(got);
            if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end
endmodule
